FILE: hw/rtl/gpsr_pkg.sv
// grid path sum range check: shared sizes and register indexes
// used by the top level, gpsr_cell_calc and the testbench; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package gpsr_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int CNT_W  = 11;
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CELL_W = 16;
  localparam int SUM_W  = 28;
  localparam int OUT_W  = 27;
  localparam int TDATA_OUT_W = 56;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic row_is0;
    logic col_is0;
    logic single_col;
  } gpsr_ctx_t;

  function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] top);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > top) begin
      r = top;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/grid_path_sum_range_check_unit.sv
// grid path sum range check, top level
// depends on gpsr_pkg, gpsr_ram and gpsr_cell_calc
//
// usage:
//   cells of a row_count x column_count grid enter on the in_ stream, one beat
//   per cell in row-major order. after the bottom-right cell one beat leaves
//   on the out_ stream with the max and min right/down path sums and the
//   zero-sum-path flag. no beat leaves for other cells.
//   row_count (byte address 0) and column_count (byte address 4) are written
//   over the cfg_ apb port while the block is idle; a write restarts the grid.
//   only bits [10:0] are kept; zero counts as 1, above 1024 as 1024; a read returns those bits.
// timing:
//   one cell per cycle sustained. a cell is registered with its line buffer
//   read issued in the same cycle; the sums of the last cell are then
//   registered in the output register that drives the result beat.
//   a stalled result holds in the output register; non-final cells keep
//   flowing, and the final cell of the next grid waits until it is taken.
// reset:
//   synchronous active-low; sizes go to 1x1, the grid restarts, and the
//   line buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module grid_path_sum_range_check_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] cell_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,   // [26:0] max_path_sum, [53:27] min_path_sum,
                                        // [54] zero_path_possible, [55] zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import gpsr_pkg::*;

  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] column_count_r;
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_eff;
  logic             cfg_wr;

  logic [ROW_W-1:0] row_index_r;
  logic [COL_W-1:0] column_index_r;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] row_inc;
  logic             row_end;
  logic             grid_end;

  logic                     s1_valid_r;
  logic signed [CELL_W-1:0] s1_cell_r;
  logic [COL_W-1:0]         s1_col_r;
  gpsr_ctx_t                s1_ctx_r;
  logic                     s1_last_r;
  logic                     s1_even_r;
  logic                     advance;
  logic                     in_acc;

  logic signed [SUM_W-1:0] left_max_r;
  logic signed [SUM_W-1:0] left_min_r;
  logic [2*SUM_W-1:0]      ram_rdata;
  logic signed [SUM_W-1:0] sum_max;
  logic signed [SUM_W-1:0] sum_min;
  logic                    zero_flag;

  logic                   out_valid_r;
  logic [TDATA_OUT_W-1:0] out_data_r;

  assign rows_eff = clamp_size(row_count_r, CNT_W'(MAX_ROWS));
  assign cols_eff = clamp_size(column_count_r, CNT_W'(MAX_COLUMNS));

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ROW_COUNT:    cfg_prdata = 32'(row_count_r);
      REG_COLUMN_COUNT: cfg_prdata = 32'(column_count_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // position bookkeeping for the next cell
  assign col_inc  = CNT_W'(column_index_r) + CNT_W'(1);
  assign row_inc  = CNT_W'(row_index_r) + CNT_W'(1);
  assign row_end  = col_inc >= cols_eff;
  assign grid_end = row_end && (row_inc >= rows_eff);

  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  gpsr_ram #(
    .WIDTH (2*SUM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_buf (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col_r),
    .wdata ({sum_min, sum_max}),
    .re    (in_acc),
    .raddr (column_index_r),
    .rdata (ram_rdata)
  );

  gpsr_cell_calc u_calc (
    .cell_value (s1_cell_r),
    .ctx        (s1_ctx_r),
    .left_max   (left_max_r),
    .left_min   (left_min_r),
    .ram_max    (ram_rdata[SUM_W-1:0]),
    .ram_min    (ram_rdata[2*SUM_W-1:SUM_W]),
    .sum_max    (sum_max),
    .sum_min    (sum_min)
  );

  assign zero_flag = s1_even_r && (sum_max >= 0) && (sum_min <= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= CNT_W'(1);
      column_count_r <= CNT_W'(1);
      row_index_r    <= '0;
      column_index_r <= '0;
      left_max_r     <= '0;
      left_min_r     <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_ROW_COUNT:    row_count_r    <= cfg_pwdata[CNT_W-1:0];
          REG_COLUMN_COUNT: column_count_r <= cfg_pwdata[CNT_W-1:0];
          default:          ;
        endcase
        row_index_r    <= '0;
        column_index_r <= '0;
        left_max_r     <= '0;
        left_min_r     <= '0;
      end else begin
        if (in_acc) begin
          if (grid_end) begin
            row_index_r    <= '0;
            column_index_r <= '0;
          end else if (row_end) begin
            row_index_r    <= row_inc[ROW_W-1:0];
            column_index_r <= '0;
          end else begin
            column_index_r <= col_inc[COL_W-1:0];
          end
        end
        if (advance) begin
          left_max_r <= sum_max;
          left_min_r <= sum_min;
        end
      end

      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cell_r           <= in_tdata;
      s1_col_r            <= column_index_r;
      s1_ctx_r.row_is0    <= (row_index_r == '0);
      s1_ctx_r.col_is0    <= (column_index_r == '0);
      s1_ctx_r.single_col <= (cols_eff == CNT_W'(1));
      s1_last_r           <= grid_end;
      s1_even_r           <= rows_eff[0] ^ cols_eff[0];
    end
    if (advance && s1_last_r) begin
      out_data_r <= {1'b0, zero_flag, sum_min[OUT_W-1:0], sum_max[OUT_W-1:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/gpsr_ram.sv
// generic single-write, single-read ram with registered read data
// standalone, no package needed
`timescale 1ns / 1ps
`default_nettype none

module gpsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gpsr_cell_calc.sv
// per-cell max/min path sum update from left and upper neighbors
// depends on gpsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpsr_cell_calc (
  input  wire logic signed [gpsr_pkg::CELL_W-1:0] cell_value,
  input  wire gpsr_pkg::gpsr_ctx_t                 ctx,
  input  wire logic signed [gpsr_pkg::SUM_W-1:0]  left_max,
  input  wire logic signed [gpsr_pkg::SUM_W-1:0]  left_min,
  input  wire logic signed [gpsr_pkg::SUM_W-1:0]  ram_max,
  input  wire logic signed [gpsr_pkg::SUM_W-1:0]  ram_min,
  output logic      signed [gpsr_pkg::SUM_W-1:0]  sum_max,
  output logic      signed [gpsr_pkg::SUM_W-1:0]  sum_min
);
  import gpsr_pkg::*;

  logic signed [SUM_W-1:0] v_ext;
  logic signed [SUM_W-1:0] up_max;
  logic signed [SUM_W-1:0] up_min;
  logic signed [SUM_W-1:0] base_max;
  logic signed [SUM_W-1:0] base_min;

  assign v_ext = SUM_W'(cell_value);

  // single column: the cell above is the one just finished
  assign up_max = ctx.single_col ? left_max : ram_max;
  assign up_min = ctx.single_col ? left_min : ram_min;

  always_comb begin
    if (ctx.row_is0 && ctx.col_is0) begin
      base_max = '0;
      base_min = '0;
    end else if (ctx.row_is0) begin
      base_max = left_max;
      base_min = left_min;
    end else if (ctx.col_is0) begin
      base_max = up_max;
      base_min = up_min;
    end else begin
      base_max = (left_max > up_max) ? left_max : up_max;
      base_min = (left_min < up_min) ? left_min : up_min;
    end
  end

  assign sum_max = base_max + v_ext;
  assign sum_min = base_min + v_ext;

endmodule

`default_nettype wire

FILE: test/tb_grid_path_sum_range_check_unit.sv
// testbench for grid_path_sum_range_check_unit: drives grids of cells on the in_ stream,
// sets grid sizes over the cfg_ apb port and checks every result beat against a predictor
// or directed values; depends on gpsr_pkg and the grid_path_sum_range_check_unit rtl
`timescale 1ns / 1ps

module tb_grid_path_sum_range_check_unit;
  import gpsr_pkg::*;

  localparam int ITEMS        = 1000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic signed [OUT_W-1:0] max_sum;
    logic signed [OUT_W-1:0] min_sum;
    logic                    zero_ok;
  } path_sums_t;

  typedef struct {
    bit          set_sizes;
    int          rows;
    int          cols;
    logic [15:0] cell_word;
    int          reps;
    bit          typed;
    int          want_max;
    int          want_min;
    bit          want_zero;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;     // [15:0] cell_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // [26:0] max_path_sum, [53:27] min_path_sum,
                                  // [54] zero_path_possible, [55] zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  grid_path_sum_range_check_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [SUM_W-1:0] up_max_mem [MAX_COLUMNS];
  logic signed [SUM_W-1:0] up_min_mem [MAX_COLUMNS];
  logic signed [SUM_W-1:0] left_max_q = '0;
  logic signed [SUM_W-1:0] left_min_q = '0;
  logic [CNT_W-1:0]        rows_reg_q = CNT_W'(1);
  logic [CNT_W-1:0]        cols_reg_q = CNT_W'(1);
  int                      row_pos = 0;
  int                      col_pos = 0;

  path_sums_t pending_sums [$];
  int         errors = 0;
  int         cells_sent = 0;
  bit         gaps_on = 1'b1;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  dir_row_t directed_rows [12] = '{
    '{1'b0, 0, 0, 16'h7fff, 1, 1'b1, 32767, 32767, 1'b0},
    '{1'b0, 0, 0, 16'h8000, 1, 1'b1, -32768, -32768, 1'b0},
    '{1'b1, 0, 0, 16'h0000, 1, 1'b1, 0, 0, 1'b0},
    '{1'b1, 1, 2, 16'h0001, 1, 1'b0, 0, 0, 1'b0},
    '{1'b0, 0, 0, 16'hffff, 1, 1'b1, 0, 0, 1'b1},
    '{1'b1, 2, 2, 16'h0001, 1, 1'b0, 0, 0, 1'b0},
    '{1'b0, 0, 0, 16'hffff, 2, 1'b0, 0, 0, 1'b0},
    '{1'b0, 0, 0, 16'h0001, 1, 1'b0, 0, 0, 1'b0},
    '{1'b1, 2, 3, 16'h7fff, 2, 1'b0, 0, 0, 1'b0},
    '{1'b1, 1, 1, 16'hfffb, 1, 1'b1, -5, -5, 1'b0},
    '{1'b1, 3, 3, 16'h7fff, 9, 1'b1, 163835, 163835, 1'b0},
    '{1'b1, 2, 3, 16'h8000, 6, 1'b1, -131072, -131072, 1'b0}
  };

  function automatic int size_in_use(input logic [CNT_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic bit advance_grid(input logic [CELL_W-1:0] raw, output path_sums_t res);
    int rows;
    int cols;
    int c;
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] mx;
    logic signed [SUM_W-1:0] mn;
    rows = size_in_use(rows_reg_q, MAX_ROWS);
    cols = size_in_use(cols_reg_q, MAX_COLUMNS);
    v = SUM_W'($signed(raw));
    c = (col_pos >= cols) ? 0 : col_pos;
    res = '0;
    if (row_pos == 0 && c == 0) begin
      mx = v;
      mn = v;
    end else if (row_pos == 0) begin
      mx = left_max_q + v;
      mn = left_min_q + v;
    end else if (c == 0) begin
      mx = up_max_mem[c] + v;
      mn = up_min_mem[c] + v;
    end else begin
      mx = ((left_max_q > up_max_mem[c]) ? left_max_q : up_max_mem[c]) + v;
      mn = ((left_min_q < up_min_mem[c]) ? left_min_q : up_min_mem[c]) + v;
    end
    up_max_mem[c] = mx;
    up_min_mem[c] = mn;
    left_max_q = mx;
    left_min_q = mn;
    c++;
    if (c >= cols) begin
      c = 0;
      row_pos++;
    end
    col_pos = c;
    if (row_pos >= rows) begin
      row_pos = 0;
      col_pos = 0;
      res.max_sum = mx[OUT_W-1:0];
      res.min_sum = mn[OUT_W-1:0];
      res.zero_ok = ((rows + cols - 1) % 2 == 0) && mx >= 0 && mn <= 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [CELL_W-1:0] pick_cell(input int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      1: return CELL_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic write_size(input logic idx, input int val);
    logic [31:0] word;
    word = $urandom;
    word[CNT_W-1:0] = CNT_W'(val);
    if ($urandom_range(0, 1) == 0) word[31:CNT_W] = '0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg_q = word[CNT_W-1:0];
    else cols_reg_q = word[CNT_W-1:0];
    row_pos = 0;
    col_pos = 0;
    left_max_q = '0;
    left_min_q = '0;
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_cell(input logic [CELL_W-1:0] cell_word, input bit typed,
                           input path_sums_t typed_res);
    path_sums_t res;
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cell_word;
    do @(posedge clk); while (!in_tready);
    if (advance_grid(cell_word, res)) pending_sums.push_back(typed ? typed_res : res);
    cells_sent++;
  endtask

  task automatic send_grid(input int count, input int mode);
    for (int k = 0; k < count; k++) send_cell(pick_cell(mode), 1'b0, '0);
  endtask

  // result beat checker
  always @(posedge clk) begin
    path_sums_t got;
    path_sums_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.max_sum = $signed(out_tdata[26:0]);
      got.min_sum = $signed(out_tdata[53:27]);
      got.zero_ok = out_tdata[54];
      if (pending_sums.size() == 0) begin
        flag_mismatch("result beat with nothing pending, max_path_sum", got.max_sum, 0);
      end else begin
        want = pending_sums.pop_front();
        if (got.max_sum != want.max_sum)
          flag_mismatch("max_path_sum", got.max_sum, want.max_sum);
        if (got.min_sum != want.min_sum)
          flag_mismatch("min_path_sum", got.min_sum, want.min_sum);
        if (got.zero_ok != want.zero_ok)
          flag_mismatch("zero_path_possible", got.zero_ok, want.zero_ok);
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (stall = 0; stall < HOLD_CYCLES; stall++) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 18);
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : cell_source
    path_sums_t want;
    int phase;
    int grid_cells;
    int mode;
    int sel;
    phase = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_sizes) begin
        settle_block();
        write_size(REG_ROW_COUNT, directed_rows[i].rows);
        write_size(REG_COLUMN_COUNT, directed_rows[i].cols);
      end
      want.max_sum = OUT_W'(directed_rows[i].want_max);
      want.min_sum = OUT_W'(directed_rows[i].want_min);
      want.zero_ok = directed_rows[i].want_zero;
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_cell(directed_rows[i].cell_word,
                  directed_rows[i].typed && k == directed_rows[i].reps - 1, want);
    end

    while (cells_sent < ITEMS) begin
      phase++;
      settle_block();
      gaps_on = $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        // result side blocked while single-cell grids keep arriving
        write_size(REG_ROW_COUNT, 1);
        write_size(REG_COLUMN_COUNT, 1);
        hold_req = 1'b1;
        send_grid(40, 1);
      end else if (phase == 3) begin
        // over-range row count, grid dropped by the next size write
        write_size(REG_ROW_COUNT, 2047);
        write_size(REG_COLUMN_COUNT, 1);
        send_grid(64, 0);
      end else begin
        sel = $urandom_range(0, 3);
        if (sel != 1)
          write_size(REG_ROW_COUNT, ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                                : $urandom_range(0, 6));
        if (sel != 0)
          write_size(REG_COLUMN_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                                   : $urandom_range(0, 8));
        grid_cells = size_in_use(rows_reg_q, MAX_ROWS) * size_in_use(cols_reg_q, MAX_COLUMNS);
        repeat ($urandom_range(1, 8)) begin
          if (cells_sent < ITEMS) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 6) ? 0 : (mode < 9) ? 1 : 2;
            send_grid(grid_cells, mode);
            if (!calm && $urandom_range(0, 9) == 0) settle_block();
          end
        end
        // partial grid, dropped by the next size write
        if (grid_cells > 1 && $urandom_range(0, 3) == 0) begin
          send_grid($urandom_range(1, grid_cells - 1), 1);
        end
      end
      calm = cells_sent >= ITEMS - 150;
    end

    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/gpsr_pkg.sv
hw/rtl/gpsr_ram.sv
hw/rtl/gpsr_cell_calc.sv
hw/rtl/grid_path_sum_range_check_unit.sv
test/tb_grid_path_sum_range_check_unit.sv
